### design/itt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itt_pkg;

    localparam int OP_W       = 3;
    localparam int SLOT_IDX_W = 6;
    localparam int PERIOD_W   = 24;
    localparam int TIME_W     = 32;

    localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic KIND_FIRED = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [PERIOD_W-1:0]   period_ticks;
        logic                  periodic;
    } cmd_t;

    typedef struct packed {
        logic                     kind;
        logic [SLOT_IDX_W-1:0]    result_slot;
        logic                     slot_present;
        logic                     slot_active;
        logic signed [TIME_W-1:0] time_left;
        logic [PERIOD_W-1:0]      slot_period;
        logic                     slot_periodic;
        logic                     last;
    } rsp_t;

endpackage

`default_nettype wire

### design/indexed_timer_table.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                      direction   payload
// cmd       cmd_valid cmd_stall cmd      in          itt_pkg::cmd_t
// rsp       rsp_valid rsp_stall rsp      out         itt_pkg::rsp_t
//
// create, remove and clear are done in idle; a query reads its slot, then waits while rsp is stalled.
// a tick scan reads one slot per cycle, unless frozen, from the single read port of the slot memory
// and checks it with the compare and add logic on the read data.
// a fired result is held back until the next one fires so that last can be set on the final one;
// rsp_stall freezes the scan only when a fire finds both holding places full.
// reset clears the flags, tick counter and control state, not the slot memory.

module indexed_timer_table #(
    parameter int SLOTS       = 64,
    parameter int PERIOD_BITS = 24
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire itt_pkg::cmd_t cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output itt_pkg::rsp_t      rsp
);

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int STORE_W = (PERIOD_BITS < itt_pkg::PERIOD_W) ? PERIOD_BITS
                                                                : itt_pkg::PERIOD_W;
    localparam int TW      = itt_pkg::TIME_W;
    localparam int MEM_W   = 1 + STORE_W + TW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_QUERY = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [TW-1:0]           now_reg, now_next;
    logic [SLOTS-1:0]        present_reg, present_next;
    logic [SLOTS-1:0]        active_reg, active_next;
    logic [SLOT_W:0]         scan_idx_reg, scan_idx_next;
    logic                    eval_valid_reg, eval_valid_next;
    logic [SLOT_W-1:0]       eval_idx_reg, eval_idx_next;
    logic                    hold_valid_reg, hold_valid_next;
    itt_pkg::rsp_t           hold_reg, hold_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    itt_pkg::rsp_t           rsp_reg, rsp_next;
    logic [itt_pkg::SLOT_IDX_W-1:0] q_slot_reg, q_slot_next;
    logic                    q_ok_reg, q_ok_next;
    logic                    q_act_reg, q_act_next;

    // slot memory: {periodic, period, deadline}
    logic [MEM_W-1:0]        slot_mem [SLOTS];
    logic [MEM_W-1:0]        rd_data_reg;
    logic                    rd_en;
    logic [SLOT_W-1:0]       rd_addr;
    logic                    wr_en;
    logic [SLOT_W-1:0]       wr_addr;
    logic [MEM_W-1:0]        wr_data;

    logic [TW-1:0]           rd_dl;
    logic [STORE_W-1:0]      rd_per;
    logic                    rd_mode;
    logic [TW-1:0]           diff;
    logic [TW-1:0]           left_old;
    logic [TW-1:0]           new_dl;
    logic                    fire;
    logic                    blocked;
    logic                    out_free;
    logic                    slot_ok;
    logic [SLOT_W-1:0]       cmd_idx;
    logic [STORE_W-1:0]      cmd_per;

    assign rd_dl    = rd_data_reg[TW-1:0];
    assign rd_per   = rd_data_reg[TW +: STORE_W];
    assign rd_mode  = rd_data_reg[MEM_W-1];
    assign diff     = now_reg - rd_dl;
    assign left_old = rd_dl - now_reg;
    assign new_dl   = now_reg + TW'(rd_per);

    assign fire = (state_reg == ST_SCAN) && eval_valid_reg && present_reg[eval_idx_reg]
                  && active_reg[eval_idx_reg] && !diff[TW-1];
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign blocked  = fire && hold_valid_reg && !out_free;

    assign cmd_idx = cmd.slot_index[SLOT_W-1:0];
    assign cmd_per = cmd.period_ticks[STORE_W-1:0];
    assign slot_ok = {1'b0, cmd.slot_index} < (itt_pkg::SLOT_IDX_W + 1)'(SLOTS);

    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        present_next    = present_reg;
        active_next     = active_reg;
        scan_idx_next   = scan_idx_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        q_slot_next     = q_slot_reg;
        q_ok_next       = q_ok_reg;
        q_act_next      = q_act_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        itt_pkg::OP_CREATE:
                        begin
                            if (slot_ok)
                            begin
                                wr_en                 = 1'b1;
                                wr_addr               = cmd_idx;
                                wr_data               = {cmd.periodic, cmd_per,
                                                         now_reg + TW'(cmd_per)};
                                present_next[cmd_idx] = 1'b1;
                                active_next[cmd_idx]  = 1'b1;
                            end
                        end
                        itt_pkg::OP_REMOVE:
                        begin
                            if (slot_ok && present_reg[cmd_idx])
                            begin
                                active_next[cmd_idx] = 1'b0;
                            end
                        end
                        itt_pkg::OP_QUERY:
                        begin
                            rd_en       = slot_ok;
                            rd_addr     = cmd_idx;
                            q_slot_next = cmd.slot_index;
                            q_ok_next   = slot_ok && present_reg[cmd_idx];
                            q_act_next  = active_reg[cmd_idx];
                            state_next  = ST_QUERY;
                        end
                        itt_pkg::OP_TICK:
                        begin
                            now_next        = now_reg + TW'(1);
                            scan_idx_next   = '0;
                            eval_valid_next = 1'b0;
                            hold_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        itt_pkg::OP_CLEAR:
                        begin
                            present_next = '0;
                            active_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_QUERY:
            begin
                if (out_free)
                begin
                    rsp_next.kind          = itt_pkg::KIND_QUERY;
                    rsp_next.result_slot   = q_slot_reg;
                    rsp_next.slot_present  = q_ok_reg;
                    rsp_next.slot_active   = q_ok_reg && q_act_reg;
                    rsp_next.time_left     = q_ok_reg ? left_old : '0;
                    rsp_next.slot_period   = q_ok_reg ? itt_pkg::PERIOD_W'(rd_per) : '0;
                    rsp_next.slot_periodic = q_ok_reg && rd_mode;
                    rsp_next.last          = 1'b1;
                    rsp_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (!blocked)
                begin
                    if (fire)
                    begin
                        wr_en   = rd_mode;
                        wr_addr = eval_idx_reg;
                        wr_data = {rd_mode, rd_per, new_dl};
                        if (!rd_mode)
                        begin
                            active_next[eval_idx_reg] = 1'b0;
                        end
                        if (hold_valid_reg)
                        begin
                            rsp_next       = hold_reg;
                            rsp_valid_next = 1'b1;
                        end
                        hold_next.kind          = itt_pkg::KIND_FIRED;
                        hold_next.result_slot   = itt_pkg::SLOT_IDX_W'(eval_idx_reg);
                        hold_next.slot_present  = 1'b1;
                        hold_next.slot_active   = rd_mode;
                        // periodic re-arm leaves exactly one period to go
                        hold_next.time_left     = rd_mode ? TW'(rd_per) : left_old;
                        hold_next.slot_period   = itt_pkg::PERIOD_W'(rd_per);
                        hold_next.slot_periodic = rd_mode;
                        hold_next.last          = 1'b0;
                        hold_valid_next         = 1'b1;
                    end

                    if (scan_idx_reg < (SLOT_W + 1)'(SLOTS))
                    begin
                        rd_en           = 1'b1;
                        rd_addr         = scan_idx_reg[SLOT_W-1:0];
                        eval_valid_next = 1'b1;
                        eval_idx_next   = scan_idx_reg[SLOT_W-1:0];
                        scan_idx_next   = scan_idx_reg + (SLOT_W + 1)'(1);
                    end
                    else
                    begin
                        eval_valid_next = 1'b0;
                        if (!eval_valid_reg)
                        begin
                            if (!hold_valid_reg)
                            begin
                                state_next = ST_IDLE;
                            end
                            else if (out_free)
                            begin
                                rsp_next        = hold_reg;
                                rsp_next.last   = 1'b1;
                                rsp_valid_next  = 1'b1;
                                hold_valid_next = 1'b0;
                                state_next      = ST_IDLE;
                            end
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            present_reg    <= '0;
            active_reg     <= '0;
            scan_idx_reg   <= '0;
            eval_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            present_reg    <= present_next;
            active_reg     <= active_next;
            scan_idx_reg   <= scan_idx_next;
            eval_valid_reg <= eval_valid_next;
            hold_valid_reg <= hold_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg <= eval_idx_next;
        hold_reg     <= hold_next;
        rsp_reg      <= rsp_next;
        q_slot_reg   <= q_slot_next;
        q_ok_reg     <= q_ok_next;
        q_act_reg    <= q_act_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    // a slot can only be active while present
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg & ~present_reg) == '0)
        else $error("active slot that is not present");

    // a frozen scan keeps its slot and its read data
    assert property (@(posedge clk) disable iff (!rst_n)
        blocked |=> $stable(eval_idx_reg) && $stable(rd_data_reg))
        else $error("scan moved while blocked");

    // a query answer is always the only and final result of its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.kind == itt_pkg::KIND_QUERY) |-> rsp.last)
        else $error("query answer without last");

    // no command is taken while a tick scan is running
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> cmd_stall)
        else $error("command taken during scan");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS       = 64;
    localparam int PERIOD_BITS = 24;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = SLOTS + 8;
    localparam int PHASE_ITEMS = 35;

    // op codes the block ignores
    localparam logic [itt_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [itt_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           cmd_stall;
    itt_pkg::cmd_t  cmd       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    itt_pkg::rsp_t  rsp;

    indexed_timer_table #(
        .SLOTS       (SLOTS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow copy of the timer table
    logic [SLOTS-1:0]             tm_present = '0;
    logic [SLOTS-1:0]             tm_active  = '0;
    logic [SLOTS-1:0]             tm_periodic = '0;
    logic [itt_pkg::PERIOD_W-1:0] tm_period [SLOTS];
    logic [itt_pkg::TIME_W-1:0]   tm_deadline [SLOTS];
    logic [itt_pkg::TIME_W-1:0]   tm_now = '0;

    itt_pkg::rsp_t expected_reports[$];
    itt_pkg::cmd_t cmd_backlog[$];

    int   queued_count   = 0;
    int   accepted_count = 0;
    int   error_count    = 0;
    int   cycle_count    = 0;
    int   sender_idle_pct = 0;
    int   rx_stall_pct    = 0;
    logic cmd_xfer        = 1'b0;

    function automatic itt_pkg::cmd_t make_cmd(logic [itt_pkg::OP_W-1:0] op, int slot,
                                               logic [itt_pkg::PERIOD_W-1:0] period,
                                               logic periodic);
        itt_pkg::cmd_t c;
        c.op           = op;
        c.slot_index   = slot[itt_pkg::SLOT_IDX_W-1:0];
        c.period_ticks = period;
        c.periodic     = periodic;
        return c;
    endfunction

    function automatic itt_pkg::rsp_t slot_report(logic kind, int slot);
        itt_pkg::rsp_t r;
        r.kind          = kind;
        r.result_slot   = slot[itt_pkg::SLOT_IDX_W-1:0];
        r.slot_present  = 1'b1;
        r.slot_active   = tm_active[slot];
        r.time_left     = tm_deadline[slot] - tm_now;
        r.slot_period   = tm_period[slot];
        r.slot_periodic = tm_periodic[slot];
        r.last          = 1'b0;
        return r;
    endfunction

    // updates the shadow table and queues the reports one command causes
    task automatic update_timer_table(input itt_pkg::cmd_t c);
        int                         s;
        logic [itt_pkg::TIME_W-1:0] lag;
        itt_pkg::rsp_t              held;
        logic                       have_held;
        s         = int'(c.slot_index);
        have_held = 1'b0;
        held      = '0;
        case (c.op)
            itt_pkg::OP_CREATE:
            begin
                tm_period[s]   = c.period_ticks;
                tm_periodic[s] = c.periodic;
                tm_deadline[s] = tm_now + itt_pkg::TIME_W'(c.period_ticks);
                tm_present[s]  = 1'b1;
                tm_active[s]   = 1'b1;
            end
            itt_pkg::OP_REMOVE:
            begin
                if (tm_present[s])
                    tm_active[s] = 1'b0;
            end
            itt_pkg::OP_QUERY:
            begin
                if (tm_present[s])
                    held = slot_report(itt_pkg::KIND_QUERY, s);
                else
                begin
                    held.kind        = itt_pkg::KIND_QUERY;
                    held.result_slot = c.slot_index;
                end
                held.last = 1'b1;
                expected_reports.push_back(held);
            end
            itt_pkg::OP_TICK:
            begin
                tm_now = tm_now + 1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tm_present[i] && tm_active[i])
                    begin
                        // wrap-safe: reached when the signed difference is not negative
                        lag = tm_now - tm_deadline[i];
                        if (!lag[itt_pkg::TIME_W-1])
                        begin
                            if (tm_periodic[i])
                                tm_deadline[i] = tm_now + itt_pkg::TIME_W'(tm_period[i]);
                            else
                                tm_active[i] = 1'b0;
                            if (have_held)
                                expected_reports.push_back(held);
                            held      = slot_report(itt_pkg::KIND_FIRED, i);
                            have_held = 1'b1;
                        end
                    end
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    expected_reports.push_back(held);
                end
            end
            itt_pkg::OP_CLEAR:
            begin
                tm_present = '0;
                tm_active  = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [itt_pkg::TIME_W-1:0] want,
                               input logic [itt_pkg::TIME_W-1:0] got);
        if (want !== got)
        begin
            if (error_count < 10)
                $display("mismatch %s: expected %0h got %0h (slot %0d)",
                         name, want, got, rsp.result_slot);
            error_count++;
        end
    endtask

    // driver: new transfer or idle on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            rsp_stall <= 1'b0;
        end
        else
        begin
            rsp_stall <= (rx_stall_pct > 0) && ($urandom_range(99) < rx_stall_pct);
            if (!cmd_valid || cmd_xfer)
            begin
                if (cmd_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    cmd       <= cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // monitor: results are checked before this edge's command is predicted
    always @(posedge clk)
    begin
        cmd_xfer = rst_n && cmd_valid && !cmd_stall;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                if (error_count < 10)
                    $display("unexpected result: kind %0d slot %0d", rsp.kind, rsp.result_slot);
                error_count++;
            end
            else
            begin
                itt_pkg::rsp_t want;
                want = expected_reports.pop_front();
                check_field("kind", itt_pkg::TIME_W'(want.kind), itt_pkg::TIME_W'(rsp.kind));
                check_field("result_slot", itt_pkg::TIME_W'(want.result_slot),
                            itt_pkg::TIME_W'(rsp.result_slot));
                check_field("slot_present", itt_pkg::TIME_W'(want.slot_present),
                            itt_pkg::TIME_W'(rsp.slot_present));
                check_field("slot_active", itt_pkg::TIME_W'(want.slot_active),
                            itt_pkg::TIME_W'(rsp.slot_active));
                check_field("time_left", want.time_left, rsp.time_left);
                check_field("slot_period", itt_pkg::TIME_W'(want.slot_period),
                            itt_pkg::TIME_W'(rsp.slot_period));
                check_field("slot_periodic", itt_pkg::TIME_W'(want.slot_periodic),
                            itt_pkg::TIME_W'(rsp.slot_periodic));
                check_field("last", itt_pkg::TIME_W'(want.last), itt_pkg::TIME_W'(rsp.last));
            end
        end
        if (cmd_xfer)
        begin
            update_timer_table(cmd);
            accepted_count++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_cmd(input itt_pkg::cmd_t c);
        cmd_backlog.push_back(c);
        queued_count++;
    endtask

    // most slots come from a small range so that commands hit live timers
    function automatic int pick_slot();
        if ($urandom_range(1))
            return int'($urandom_range(SLOTS - 1));
        return int'($urandom_range(7));
    endfunction

    task automatic queue_random_cmd();
        int                           roll;
        logic [itt_pkg::PERIOD_W-1:0] period;
        roll = $urandom_range(99);
        if ($urandom_range(9) == 0)
            period = itt_pkg::PERIOD_W'($urandom_range(32'h00FF_FFFF));
        else
            period = itt_pkg::PERIOD_W'($urandom_range(6));
        if (roll < 30)
            queue_cmd(make_cmd(itt_pkg::OP_CREATE, pick_slot(), period,
                               1'($urandom_range(1))));
        else if (roll < 40)
            queue_cmd(make_cmd(itt_pkg::OP_REMOVE, pick_slot(), period,
                               1'($urandom_range(1))));
        else if (roll < 60)
            queue_cmd(make_cmd(itt_pkg::OP_QUERY, pick_slot(), period,
                               1'($urandom_range(1))));
        else if (roll < 93)
            queue_cmd(make_cmd(itt_pkg::OP_TICK, pick_slot(), period,
                               1'($urandom_range(1))));
        else if (roll < 96)
            queue_cmd(make_cmd(itt_pkg::OP_CLEAR, pick_slot(), period,
                               1'($urandom_range(1))));
        else
            queue_cmd(make_cmd(itt_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                               pick_slot(), period, 1'($urandom_range(1))));
    endtask

    // the wait on the results makes the sender hold off until the block drains
    task automatic run_phase(input int idle_pct, input int stall_pct, input int count,
                             input logic fill_all);
        sender_idle_pct = idle_pct;
        rx_stall_pct    = stall_pct;
        if (fill_all)
        begin
            for (int i = 0; i < SLOTS; i++)
                queue_cmd(make_cmd(itt_pkg::OP_CREATE, i,
                                   itt_pkg::PERIOD_W'($urandom_range(2)),
                                   1'($urandom_range(1))));
            queue_cmd(make_cmd(itt_pkg::OP_TICK, 0, '0, 1'b0));
        end
        repeat (count)
            queue_random_cmd();
        wait (accepted_count == queued_count);
        wait (expected_reports.size() == 0);
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            tm_period[i]   = '0;
            tm_deadline[i] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // absent slots, full-scale and zero periods, removed and overwritten slots
        queue_cmd(make_cmd(itt_pkg::OP_QUERY, 0, '0, 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_QUERY, SLOTS - 1, '1, 1'b1));
        queue_cmd(make_cmd(itt_pkg::OP_TICK, 0, '0, 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_CREATE, 0, '0, 1'b1));
        queue_cmd(make_cmd(itt_pkg::OP_CREATE, SLOTS - 1, '1, 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_CREATE, 5, itt_pkg::PERIOD_W'(1), 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_CREATE, 9, itt_pkg::PERIOD_W'(2), 1'b1));
        queue_cmd(make_cmd(itt_pkg::OP_CREATE, 12, itt_pkg::PERIOD_W'(3), 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_REMOVE, 12, '0, 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_REMOVE, 40, '0, 1'b0));
        repeat (3)
            queue_cmd(make_cmd(itt_pkg::OP_TICK, 0, '0, 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_QUERY, 12, '0, 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_QUERY, SLOTS - 1, '0, 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_QUERY, 5, '0, 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_QUERY, 9, '0, 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_CREATE, 5, itt_pkg::PERIOD_W'(4), 1'b1));
        queue_cmd(make_cmd(OP_SPARE_FIRST, SLOTS - 1, '1, 1'b1));
        queue_cmd(make_cmd(OP_SPARE_LAST, 3, 24'h55_5555, 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_CLEAR, 0, '0, 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_QUERY, 0, '0, 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_TICK, 0, '0, 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_CREATE, 30, 24'hAA_AAAA, 1'b0));
        queue_cmd(make_cmd(itt_pkg::OP_QUERY, 30, '0, 1'b0));

        run_phase(0, 0, PHASE_ITEMS, 1'b0);
        run_phase(76, 0, PHASE_ITEMS, 1'b0);
        run_phase(0, 76, PHASE_ITEMS, 1'b1);
        run_phase(25, 25, PHASE_ITEMS, 1'b0);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0 && expected_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
